@@ hw/rtl/text_console_writer_top_assert.svh @@
// assertion macros used by the checker file
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// antecedent holds, consequent checked on the next clock
`define TCW_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

// same-cycle implication, ignored while reset is low
`define TCW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_IDX_W = 11;
    localparam int CELL_W     = CHAR_W + ATTR_W;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd15;

    // register index taken from paddr[2]
    localparam logic REG_TEXT_ATTR = 1'b0;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_CHAR    = 3'd0,
        OP_NEWLINE = 3'd1,
        OP_CLEAR   = 3'd2,
        OP_READ    = 3'd3,
        OP_REPORT  = 3'd4
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [CHAR_W-1:0]     ch;
        logic [CELL_IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic init_busy;
    } t_back_stat;

endpackage

`default_nettype wire

@@ hw/rtl/tcw_front.sv @@
`default_nettype none

module tcw_front import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                  i_start,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [CHAR_W-1:0]     i_char_code,
    input  wire logic [CELL_IDX_W-1:0] i_cell_index,
    input  wire logic                  i_q_full,
    input  wire t_back_stat            i_stat,
    output logic                       o_busy,
    output logic                       o_push,
    output t_cmd                       o_cmd
);

    localparam int          CELLS   = ROWS * COLUMNS;
    localparam logic [31:0] CELLS32 = 32'(CELLS);

    logic in_range;

    assign in_range = {21'b0, i_cell_index} < CELLS32;
    assign o_busy   = i_q_full | i_stat.init_busy;
    assign o_push   = i_start & ~o_busy;

    always_comb begin
        o_cmd.ch  = i_char_code;
        o_cmd.idx = '0;
        unique case (i_command)
            CMD_PUT: begin
                o_cmd.op = (i_char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_CHAR;
            end
            CMD_CLEAR: begin
                o_cmd.op = OP_CLEAR;
            end
            CMD_READ: begin
                if (in_range) begin
                    o_cmd.op  = OP_READ;
                    o_cmd.idx = i_cell_index;
                end else begin
                    o_cmd.op = OP_REPORT;
                end
            end
            default: begin
                o_cmd.op = OP_REPORT;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/tcw_queue.sv @@
`default_nettype none

module tcw_queue import tcw_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output logic      o_empty,
    output logic      o_full
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_head  = r_slot[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tcw_back.sv @@
`default_nettype none

module tcw_back import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [ATTR_W-1:0]     i_text_attr,
    input  wire t_cmd                  i_head,
    input  wire logic                  i_q_empty,
    output logic                       o_pop,
    output t_back_stat                 o_stat,
    output logic                       o_valid,
    output logic [CHAR_W-1:0]          o_cell_char,
    output logic [ATTR_W-1:0]          o_cell_attribute,
    output logic [CELL_IDX_W-1:0]      o_cursor_cell
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int BODY  = CELLS - COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = $clog2(CELLS + 1);
    localparam int COLW  = $clog2(COLUMNS);

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_READ   = 6'b000100,
        S_CLEAR  = 6'b001000,
        S_SCROLL = 6'b010000,
        S_PUT    = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [IW-1:0]   r_idx, n_idx;
    logic [IW-1:0]   r_cursor, n_cursor;
    logic [COLW-1:0] r_col, n_col;
    logic [CHAR_W-1:0] r_ch, n_ch;
    logic r_nl, n_nl;
    logic r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_out_char, n_out_char;
    logic [ATTR_W-1:0]     r_out_attr, n_out_attr;
    logic [CELL_IDX_W-1:0] r_out_cursor, n_out_cursor;

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdata;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [CELL_W-1:0] mem_wd;
    logic [AW-1:0]     mem_ra;

    logic              do_put;
    logic              put_nl;
    logic [CHAR_W-1:0] put_ch;
    logic [IW-1:0]     put_cursor;
    logic [COLW-1:0]   put_col;
    logic [IW:0]       scr_rd_sum;
    logic [IW-1:0]     scr_wr_idx;

    // cursor step for one put, taken from the queue head or the held command
    always_comb begin
        put_nl = (r_state == S_PUT) ? r_nl : (i_head.op == OP_NEWLINE);
        put_ch = (r_state == S_PUT) ? r_ch : i_head.ch;
        if (put_nl) begin
            put_cursor = r_cursor - IW'(r_col) + IW'(COLUMNS);
            put_col    = '0;
        end else begin
            put_cursor = r_cursor + 1'b1;
            put_col    = (r_col == COLW'(COLUMNS - 1)) ? '0 : r_col + 1'b1;
        end
    end

    assign scr_rd_sum = {1'b0, r_idx} + (IW + 1)'(COLUMNS);
    assign scr_wr_idx = r_idx - 1'b1;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cursor     = r_cursor;
        n_col        = r_col;
        n_ch         = r_ch;
        n_nl         = r_nl;
        n_out_valid  = 1'b0;
        n_out_char   = '0;
        n_out_attr   = '0;
        n_out_cursor = r_out_cursor;
        o_pop        = 1'b0;
        do_put       = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = '0;
        mem_wd       = '0;
        mem_ra       = '0;

        unique case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                mem_wa = r_idx[AW-1:0];
                mem_wd = {BLANK_CODE, ATTR_RESET};
                n_idx  = r_idx + 1'b1;
                if (r_idx == IW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                mem_ra = AW'(i_head.idx);
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    unique case (i_head.op) inside
                        OP_CHAR, OP_NEWLINE: begin
                            if (r_cursor == IW'(CELLS)) begin
                                n_ch    = i_head.ch;
                                n_nl    = (i_head.op == OP_NEWLINE);
                                n_idx   = '0;
                                n_state = S_SCROLL;
                            end else begin
                                do_put = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_idx   = '0;
                            n_state = S_CLEAR;
                        end
                        OP_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                            n_out_valid  = 1'b1;
                            n_out_cursor = CELL_IDX_W'(r_cursor);
                        end
                    endcase
                end
            end
            S_READ: begin
                n_out_valid  = 1'b1;
                n_out_char   = r_rdata[CELL_W-1:ATTR_W];
                n_out_attr   = r_rdata[ATTR_W-1:0];
                n_out_cursor = CELL_IDX_W'(r_cursor);
                n_state      = S_IDLE;
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_idx[AW-1:0];
                mem_wd = {BLANK_CODE, i_text_attr};
                n_idx  = r_idx + 1'b1;
                if (r_idx == IW'(CELLS - 1)) begin
                    n_cursor     = '0;
                    n_col        = '0;
                    n_out_valid  = 1'b1;
                    n_out_cursor = '0;
                    n_state      = S_IDLE;
                end
            end
            S_SCROLL: begin
                // read the row below, write it one row up from the registered read data; the last row is blanked
                mem_ra = (scr_rd_sum < (IW + 1)'(CELLS)) ? scr_rd_sum[AW-1:0] : '0;
                if (r_idx != '0) begin
                    mem_we = 1'b1;
                    mem_wa = scr_wr_idx[AW-1:0];
                    mem_wd = (scr_wr_idx < IW'(BODY)) ? r_rdata
                                                      : {BLANK_CODE, i_text_attr};
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == IW'(CELLS)) begin
                    n_cursor = IW'(BODY);
                    n_col    = '0;
                    n_state  = S_PUT;
                end
            end
            S_PUT: begin
                do_put  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_put) begin
            if (!put_nl) begin
                mem_we = 1'b1;
                mem_wa = r_cursor[AW-1:0];
                mem_wd = {put_ch, i_text_attr};
            end
            n_cursor     = put_cursor;
            n_col        = put_col;
            n_out_valid  = 1'b1;
            n_out_cursor = CELL_IDX_W'(put_cursor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_cursor    <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cursor    <= n_cursor;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch         <= n_ch;
        r_nl         <= n_nl;
        r_out_char   <= n_out_char;
        r_out_attr   <= n_out_attr;
        r_out_cursor <= n_out_cursor;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[mem_ra];
    end

    assign o_stat.init_busy = (r_state == S_INIT);
    assign o_valid          = r_out_valid;
    assign o_cell_char      = r_out_char;
    assign o_cell_attribute = r_out_attr;
    assign o_cursor_cell    = r_out_cursor;

endmodule

`default_nettype wire

@@ hw/rtl/text_console_writer_top.sv @@
// channel   | direction | handshake                     | payload
// ----------+-----------+-------------------------------+--------------------------------------
// command   | in        | start, busy                   | i_command, i_char_code, i_cell_index
// result    | out       | o_valid (one-cycle strobe)    | o_cell_char, o_cell_attribute,
//           |           |                               | o_cursor_cell
// config    | in        | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// plain put, unused command and out-of-range read are done in the idle state; a read goes on through the read state
// clear: a sweep over every cell, one cell write per cycle on the single store write port
// put with the cursor past the last cell: a scroll sweep first, then the put
// after reset a clearing pass holds busy high
// a two-entry command queue lets start be taken while the engine works; busy when full
// the receiver cannot stall: each result is a single-cycle strobe

`default_nettype none

module text_console_writer_top import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // command transaction
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [CHAR_W-1:0]     i_char_code,
    input  wire logic [CELL_IDX_W-1:0] i_cell_index,
    // result transaction
    output logic                       o_valid,
    output logic [CHAR_W-1:0]          o_cell_char,
    output logic [ATTR_W-1:0]          o_cell_attribute,
    output logic [CELL_IDX_W-1:0]      o_cursor_cell,
    // register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // attribute register, stored with every written cell and with cells blanked by clear or scroll
    logic [ATTR_W-1:0] r_text_attr;
    logic              cfg_wr;

    // front to queue
    logic q_push;
    t_cmd q_in;
    logic q_full;

    // queue to engine
    t_cmd       q_head;
    logic       q_empty;
    logic       q_pop;
    t_back_stat back_stat;

    // register port: no wait states, index is paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr <= ATTR_RESET;
        end else if (cfg_wr && paddr[2] == REG_TEXT_ATTR) begin
            r_text_attr <= pwdata[ATTR_W-1:0];
        end
    end

    // read back the attribute, anything past the list reads zero
    assign prdata = (paddr[2] == REG_TEXT_ATTR) ? {24'b0, r_text_attr} : 32'b0;

    // front: take the transaction and sort it into an engine operation
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_start      (start),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_q_full     (q_full),
        .i_stat       (back_stat),
        .o_busy       (busy),
        .o_push       (q_push),
        .o_cmd        (q_in)
    );

    // short queue between front and engine
    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // engine: screen store, cursor, clear and scroll sweeps, result register
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_text_attr      (r_text_attr),
        .i_head           (q_head),
        .i_q_empty        (q_empty),
        .o_pop            (q_pop),
        .o_stat           (back_stat),
        .o_valid          (o_valid),
        .o_cell_char      (o_cell_char),
        .o_cell_attribute (o_cell_attribute),
        .o_cursor_cell    (o_cursor_cell)
    );

endmodule

`default_nettype wire

@@ hw/rtl/tcw_checker.sv @@
`default_nettype none

`include "text_console_writer_top_assert.svh"

module tcw_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata
);

    // no result leaks out of reset
    `TCW_ASSERT_NEXT(a_rst_no_result, i_clk, !i_rst_n, !o_valid, "result strobe after reset")

    // clearing pass holds off commands right after reset
    `TCW_ASSERT_NEXT(a_rst_busy, i_clk, !i_rst_n, busy, "not busy after reset")

    // attribute write is visible on the next read
    `TCW_ASSERT_NEXT(a_attr_write, i_clk, i_rst_n && psel && penable && pwrite && !paddr[2], paddr[2] || prdata[7:0] == $past(pwdata[7:0]), "attribute write lost")

    // read data carries only the attribute byte
    `TCW_ASSERT_NOW(a_read_upper, i_clk, i_rst_n, psel && !pwrite, prdata[31:8] == 24'd0, "upper read bits set")

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .busy    (busy),
    .o_valid (o_valid),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata)
);

`default_nettype wire
